[hdl/ffa_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and default link types of the first-fit allocator.
// No dependencies; the design files refer to it by scoped names and the bench imports it.
package ffa_pkg;

    localparam int CHUNK_SLOTS_DEF  = 16;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int ADDR_BITS_DEF    = 20;

    // Fixed field widths of the request, result and register ports
    localparam int REG_BITS       = 20;
    localparam int STATUS_BITS    = 3;
    localparam int CFG_INDEX_BITS = 1;

    localparam int SLOT_BITS_DEF = $clog2(CHUNK_SLOTS_DEF);
    localparam int CNT_BITS_DEF  = $clog2(CHUNK_SLOTS_DEF + 1);
    localparam int CMP_BITS_DEF  = (ADDR_BITS_DEF > REG_BITS) ? ADDR_BITS_DEF : REG_BITS;

    localparam logic [REG_BITS-1:0] HEAP_BASE_RESET  = 20'd4096;
    localparam logic [REG_BITS-1:0] HEAP_LIMIT_RESET = 20'hFFFFF;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEAP_BASE  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEAP_LIMIT = 1'b1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_REUSED     = 3'd0,
        ST_NEW        = 3'd1,
        ST_ZERO       = 3'd2,
        ST_HEAP_FULL  = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_FREED      = 3'd5,
        ST_NULL       = 3'd6,
        ST_BAD_FREE   = 3'd7
    } status_t;

    // Free chain operations
    typedef enum logic [1:0] {
        FOP_HOLD   = 2'd0,
        FOP_PUSH   = 2'd1,
        FOP_ROTATE = 2'd2,
        FOP_DROP   = 2'd3
    } free_op_t;

    // Default link types at the default sizes; the top level hands down its own
    typedef struct packed {
        logic [SLOT_BITS_DEF-1:0] slot;
        logic [REG_BITS-1:0]      bytes;
        logic [ADDR_BITS_DEF-1:0] user;
    } entry_t;

    typedef struct packed {
        logic   valid;
        logic   found;
        logic   was_free;
        entry_t ent;
    } probe_t;

    typedef struct packed {
        logic [CNT_BITS_DEF-1:0]  count;
        logic                     clear_en;
        logic                     set_en;
        logic [SLOT_BITS_DEF-1:0] mod_slot;
        logic                     write_en;
        entry_t                   wr;
        logic [CMP_BITS_DEF-1:0]  match_addr;
    } slot_ctl_t;

    typedef struct packed {
        free_op_t                 op;
        logic [SLOT_BITS_DEF-1:0] tail;
        entry_t                   head_in;
    } free_ctl_t;

endpackage

[hdl/ffa_slot_cell.sv]
`timescale 1ns / 1ps
// One chunk table cell: user address, size and free flag of one carved chunk,
// plus one stage of the address probe chain. Depends on ffa_pkg.
module ffa_slot_cell #(
    parameter int  IDX        = 0,
    parameter int  SLOT_BITS  = ffa_pkg::SLOT_BITS_DEF,
    parameter int  CNT_BITS   = ffa_pkg::CNT_BITS_DEF,
    parameter int  CMP_BITS   = ffa_pkg::CMP_BITS_DEF,
    parameter type entry_t    = ffa_pkg::entry_t,
    parameter type probe_t    = ffa_pkg::probe_t,
    parameter type slot_ctl_t = ffa_pkg::slot_ctl_t
) (
    input  logic      clk,
    input  logic      rst_n,
    input  slot_ctl_t ctl,
    input  probe_t    probe_in,
    output probe_t    probe_out
);

    localparam logic [SLOT_BITS-1:0] MY_SLOT  = SLOT_BITS'(IDX);
    localparam logic [CNT_BITS-1:0]  MY_COUNT = CNT_BITS'(IDX);

    entry_t ent_reg;
    logic   is_free_reg;
    probe_t probe_reg;
    probe_t probe_next;
    logic   carved;
    logic   hit;

    assign carved = (MY_COUNT < ctl.count);
    // only the first carved chunk with this user address answers
    assign hit = probe_in.valid && !probe_in.found && carved &&
                 (CMP_BITS'(ent_reg.user) == ctl.match_addr);

    always_comb
    begin
        probe_next = probe_in;
        if (hit)
        begin
            probe_next.found    = 1'b1;
            probe_next.was_free = is_free_reg;
            probe_next.ent      = ent_reg;
        end
    end

    // the written slot field already equals this cell's slot
    always_ff @(posedge clk)
    begin
        if (ctl.write_en && (ctl.wr.slot == MY_SLOT))
        begin
            ent_reg <= ctl.wr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_free_reg <= 1'b0;
            probe_reg   <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
            if (ctl.write_en && (ctl.wr.slot == MY_SLOT))
            begin
                is_free_reg <= 1'b0;
            end
            else if (ctl.clear_en && (ctl.mod_slot == MY_SLOT))
            begin
                is_free_reg <= 1'b0;
            end
            else if (ctl.set_en && (ctl.mod_slot == MY_SLOT))
            begin
                is_free_reg <= 1'b1;
            end
        end
    end

    assign probe_out = probe_reg;

endmodule

[hdl/ffa_free_cell.sv]
`timescale 1ns / 1ps
// One free list cell: holds the list entry at its position and moves it to a
// neighbor on push, rotate and drop. Depends on ffa_pkg.
module ffa_free_cell #(
    parameter int  IDX        = 0,
    parameter int  SLOT_BITS  = ffa_pkg::SLOT_BITS_DEF,
    parameter type entry_t    = ffa_pkg::entry_t,
    parameter type free_ctl_t = ffa_pkg::free_ctl_t
) (
    input  logic      clk,
    input  free_ctl_t ctl,
    input  entry_t    left,
    input  entry_t    right,
    output entry_t    q
);

    localparam logic [SLOT_BITS-1:0] MY_POS = SLOT_BITS'(IDX);

    entry_t ent_reg;
    entry_t ent_next;

    always_comb
    begin
        ent_next = ent_reg;
        unique case (ctl.op)
            ffa_pkg::FOP_HOLD:
            begin
                ent_next = ent_reg;
            end
            ffa_pkg::FOP_PUSH:
            begin
                ent_next = (IDX == 0) ? ctl.head_in : left;
            end
            ffa_pkg::FOP_ROTATE:
            begin
                // the head wraps around to the tail
                if (MY_POS < ctl.tail)
                    ent_next = right;
                else if (MY_POS == ctl.tail)
                    ent_next = ctl.head_in;
            end
            ffa_pkg::FOP_DROP:
            begin
                if (MY_POS < ctl.tail)
                    ent_next = right;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign q = ent_reg;

endmodule

[hdl/first_fit_free_list_allocator.sv]
`timescale 1ns / 1ps
// First-fit free list allocator, top level: request FSM, registers and the two cell chains.
// Depends on ffa_pkg, ffa_slot_cell and ffa_free_cell.
//
// Each request transfer is an allocate (mode 0) or a free (mode 1) and gives exactly one
// result transfer. The block takes one request at a time. An allocate walks the free list,
// which sits in a chain of cells that rotates one place per cycle. A reuse examines each
// free entry once, closes the scan, passes the finish state and then the output register.
// A new chunk, heap full or table full result also passes the carve decision before the
// finish state. A free sends the address down the chunk table chain, one cell per cycle.
// A zero size allocate and a null free go straight to the finish state. The result waits
// in an output register, so the next request is taken while it is stalled.
// Write heap_base and heap_limit only while the block is idle; a heap_base write also moves
// the break pointer while no chunk has been carved. There is no clearing pass after reset.
module first_fit_free_list_allocator #(
    parameter int CHUNK_SLOTS  = ffa_pkg::CHUNK_SLOTS_DEF,
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
    parameter int ADDR_BITS    = ffa_pkg::ADDR_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_write_en,
    input  logic [ffa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ffa_pkg::REG_BITS-1:0]         cfg_data,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 mode,
    input  logic [ffa_pkg::REG_BITS-1:0]         request_size,
    input  logic [ffa_pkg::REG_BITS-1:0]         free_address,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [ADDR_BITS-1:0]                 user_address,
    output logic [ffa_pkg::STATUS_BITS-1:0]      status
);

    localparam int REG_BITS  = ffa_pkg::REG_BITS;
    localparam int SLOT_BITS = $clog2(CHUNK_SLOTS);
    localparam int CNT_BITS  = $clog2(CHUNK_SLOTS + 1);
    localparam int CMP_BITS  = (ADDR_BITS > REG_BITS) ? ADDR_BITS : REG_BITS;
    localparam int SUM_BITS  = CMP_BITS + 2;

    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(CHUNK_SLOTS);

    typedef struct packed {
        logic [SLOT_BITS-1:0] slot;
        logic [REG_BITS-1:0]  bytes;
        logic [ADDR_BITS-1:0] user;
    } entry_t;

    typedef struct packed {
        logic   valid;
        logic   found;
        logic   was_free;
        entry_t ent;
    } probe_t;

    typedef struct packed {
        logic [CNT_BITS-1:0]  count;
        logic                 clear_en;
        logic                 set_en;
        logic [SLOT_BITS-1:0] mod_slot;
        logic                 write_en;
        entry_t               wr;
        logic [CMP_BITS-1:0]  match_addr;
    } slot_ctl_t;

    typedef struct packed {
        ffa_pkg::free_op_t    op;
        logic [SLOT_BITS-1:0] tail;
        entry_t               head_in;
    } free_ctl_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_CARVE  = 5'b00100,
        S_PROBE  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [REG_BITS-1:0]    heap_base_reg, heap_base_next;
    logic [REG_BITS-1:0]    heap_limit_reg, heap_limit_next;
    logic [ADDR_BITS-1:0]   bp_reg, bp_next;
    logic [CNT_BITS-1:0]    chunk_count_reg, chunk_count_next;
    logic [CNT_BITS-1:0]    free_count_reg, free_count_next;
    logic [REG_BITS-1:0]    size_reg, size_next;
    logic [CMP_BITS-1:0]    addr_reg, addr_next;
    logic [CNT_BITS-1:0]    steps_reg, steps_next;
    logic [SLOT_BITS-1:0]   tail_reg, tail_next;
    logic                   found_reg, found_next;
    logic [ADDR_BITS-1:0]   found_user_reg, found_user_next;
    logic [ADDR_BITS-1:0]   res_addr_reg, res_addr_next;
    ffa_pkg::status_t       res_status_reg, res_status_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ADDR_BITS-1:0]   out_addr_reg, out_addr_next;
    ffa_pkg::status_t       out_status_reg, out_status_next;

    logic                   accept;
    logic [SUM_BITS-1:0]    carve_user_sum;
    logic [SUM_BITS-1:0]    carve_next_sum;
    logic                   head_fits;
    logic                   free_bad;
    logic [CNT_BITS-1:0]    count_less_one;

    slot_ctl_t              slot_ctl;
    free_ctl_t              free_ctl;
    probe_t                 probe_launch;
    probe_t                 probe_q [CHUNK_SLOTS];
    probe_t                 probe_end;
    entry_t                 free_q [CHUNK_SLOTS];

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    assign carve_user_sum = SUM_BITS'(bp_reg) + SUM_BITS'(HEADER_BYTES);
    assign carve_next_sum = carve_user_sum + SUM_BITS'(size_reg);
    assign head_fits      = (free_q[0].bytes >= size_reg);
    assign probe_end      = probe_q[CHUNK_SLOTS-1];
    assign count_less_one = free_count_reg - CNT_BITS'(1);
    assign free_bad       = !probe_end.found || probe_end.was_free ||
                            (free_count_reg == FULL_COUNT);

    always_comb
    begin
        state_next       = state_reg;
        heap_base_next   = heap_base_reg;
        heap_limit_next  = heap_limit_reg;
        bp_next          = bp_reg;
        chunk_count_next = chunk_count_reg;
        free_count_next  = free_count_reg;
        size_next        = size_reg;
        addr_next        = addr_reg;
        steps_next       = steps_reg;
        tail_next        = tail_reg;
        found_next       = found_reg;
        found_user_next  = found_user_reg;
        res_addr_next    = res_addr_reg;
        res_status_next  = res_status_reg;
        out_addr_next    = out_addr_reg;
        out_status_next  = out_status_reg;
        out_valid_next   = out_valid_reg && out_stall;

        slot_ctl            = '0;
        slot_ctl.count      = chunk_count_reg;
        slot_ctl.match_addr = addr_reg;
        free_ctl            = '0;
        free_ctl.op         = ffa_pkg::FOP_HOLD;
        free_ctl.tail       = tail_reg;
        free_ctl.head_in    = free_q[0];
        probe_launch        = '0;

        // the user must write configuration only while idle; the block does not enforce it
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                ffa_pkg::CFG_HEAP_BASE:
                begin
                    heap_base_next = cfg_data;
                    if (chunk_count_reg == '0)
                        bp_next = ADDR_BITS'(cfg_data);
                end
                ffa_pkg::CFG_HEAP_LIMIT:
                begin
                    heap_limit_next = cfg_data;
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_addr_next = '0;
                    if (mode == ffa_pkg::MODE_ALLOC)
                    begin
                        if (request_size == '0)
                        begin
                            res_status_next = ffa_pkg::ST_ZERO;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            size_next  = request_size;
                            steps_next = free_count_reg;
                            tail_next  = count_less_one[SLOT_BITS-1:0];
                            found_next = 1'b0;
                            state_next = S_SCAN;
                        end
                    end
                    else if (free_address == '0)
                    begin
                        res_status_next = ffa_pkg::ST_NULL;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        // launch the address down the chunk table chain; the first
                        // cell compares against the incoming address this cycle
                        addr_next           = CMP_BITS'(free_address);
                        slot_ctl.match_addr = CMP_BITS'(free_address);
                        probe_launch.valid  = 1'b1;
                        state_next          = S_PROBE;
                    end
                end
            end
            S_SCAN:
            begin
                if (steps_reg != '0)
                begin
                    steps_next = steps_reg - CNT_BITS'(1);
                    if (!found_reg && head_fits)
                    begin
                        // take the head out of the list for good
                        free_ctl.op       = ffa_pkg::FOP_DROP;
                        tail_next         = tail_reg - SLOT_BITS'(1);
                        free_count_next   = count_less_one;
                        found_next        = 1'b1;
                        found_user_next   = free_q[0].user;
                        slot_ctl.clear_en = 1'b1;
                        slot_ctl.mod_slot = free_q[0].slot;
                    end
                    else
                    begin
                        free_ctl.op = ffa_pkg::FOP_ROTATE;
                    end
                end
                else if (found_reg)
                begin
                    res_addr_next   = found_user_reg;
                    res_status_next = ffa_pkg::ST_REUSED;
                    state_next      = S_FINISH;
                end
                else
                begin
                    state_next = S_CARVE;
                end
            end
            S_CARVE:
            begin
                state_next = S_FINISH;
                if (carve_next_sum > SUM_BITS'(heap_limit_reg))
                begin
                    res_status_next = ffa_pkg::ST_HEAP_FULL;
                end
                else if (chunk_count_reg == FULL_COUNT)
                begin
                    res_status_next = ffa_pkg::ST_TABLE_FULL;
                end
                else
                begin
                    slot_ctl.write_en = 1'b1;
                    slot_ctl.wr.slot  = chunk_count_reg[SLOT_BITS-1:0];
                    slot_ctl.wr.bytes = size_reg;
                    slot_ctl.wr.user  = carve_user_sum[ADDR_BITS-1:0];
                    chunk_count_next  = chunk_count_reg + CNT_BITS'(1);
                    bp_next           = carve_next_sum[ADDR_BITS-1:0];
                    res_addr_next     = carve_user_sum[ADDR_BITS-1:0];
                    res_status_next   = ffa_pkg::ST_NEW;
                end
            end
            S_PROBE:
            begin
                if (probe_end.valid)
                begin
                    state_next = S_FINISH;
                    if (free_bad)
                    begin
                        res_status_next = ffa_pkg::ST_BAD_FREE;
                    end
                    else
                    begin
                        // mark the chunk free and push it at the list head
                        slot_ctl.set_en   = 1'b1;
                        slot_ctl.mod_slot = probe_end.ent.slot;
                        free_ctl.op       = ffa_pkg::FOP_PUSH;
                        free_ctl.head_in  = probe_end.ent;
                        free_count_next   = free_count_reg + CNT_BITS'(1);
                        res_status_next   = ffa_pkg::ST_FREED;
                    end
                end
            end
            S_FINISH:
            begin
                // hold until the output register is empty or being drained
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            heap_base_reg   <= ffa_pkg::HEAP_BASE_RESET;
            heap_limit_reg  <= ffa_pkg::HEAP_LIMIT_RESET;
            bp_reg          <= ADDR_BITS'(ffa_pkg::HEAP_BASE_RESET);
            chunk_count_reg <= '0;
            free_count_reg  <= '0;
            steps_reg       <= '0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            heap_base_reg   <= heap_base_next;
            heap_limit_reg  <= heap_limit_next;
            bp_reg          <= bp_next;
            chunk_count_reg <= chunk_count_next;
            free_count_reg  <= free_count_next;
            steps_reg       <= steps_next;
            found_reg       <= found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // request and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        tail_reg       <= tail_next;
        found_user_reg <= found_user_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    // chunk table chain: the probe advances one cell per cycle
    for (genvar k = 0; k < CHUNK_SLOTS; k++)
    begin : g_slot
        probe_t probe_in_k;
        if (k == 0)
        begin : g_first
            assign probe_in_k = probe_launch;
        end
        else
        begin : g_rest
            assign probe_in_k = probe_q[k-1];
        end

        ffa_slot_cell #(
            .IDX        (k),
            .SLOT_BITS  (SLOT_BITS),
            .CNT_BITS   (CNT_BITS),
            .CMP_BITS   (CMP_BITS),
            .entry_t    (entry_t),
            .probe_t    (probe_t),
            .slot_ctl_t (slot_ctl_t)
        ) u_slot (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (slot_ctl),
            .probe_in  (probe_in_k),
            .probe_out (probe_q[k])
        );
    end

    // free list chain: position 0 is the most recently freed chunk
    for (genvar k = 0; k < CHUNK_SLOTS; k++)
    begin : g_free
        entry_t left_k;
        entry_t right_k;
        if (k == 0)
        begin : g_left_end
            assign left_k = free_ctl.head_in;
        end
        else
        begin : g_left
            assign left_k = free_q[k-1];
        end
        if (k == CHUNK_SLOTS - 1)
        begin : g_right_end
            assign right_k = free_ctl.head_in;
        end
        else
        begin : g_right
            assign right_k = free_q[k+1];
        end

        ffa_free_cell #(
            .IDX        (k),
            .SLOT_BITS  (SLOT_BITS),
            .entry_t    (entry_t),
            .free_ctl_t (free_ctl_t)
        ) u_free (
            .clk   (clk),
            .ctl   (free_ctl),
            .left  (left_k),
            .right (right_k),
            .q     (free_q[k])
        );
    end

    assign out_valid    = out_valid_reg;
    assign user_address = out_addr_reg;
    assign status       = out_status_reg;

    // free entries are always a subset of the carved chunks
    a_free_within_carved: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= chunk_count_reg)
        else $error("free count exceeds carved chunk count");

    a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_count_reg <= FULL_COUNT)
        else $error("chunk count beyond table size");

    // a probe only reaches the end of the chain while a free waits for it
    a_probe_in_probe_state: assert property (@(posedge clk) disable iff (!rst_n)
        probe_end.valid |-> state_reg == S_PROBE)
        else $error("probe arrived outside free request");

    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && (steps_reg == '0) |=>
        (state_reg == S_FINISH) || (state_reg == S_CARVE))
        else $error("free list scan did not terminate");

    a_fail_has_null: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ffa_pkg::ST_REUSED) && (status != ffa_pkg::ST_NEW)
        |-> user_address == '0)
        else $error("nonzero address on a failed or free result");

endmodule

[bench/tb_first_fit_free_list_allocator.sv]
`timescale 1ns / 1ps
// Self-checking bench for first_fit_free_list_allocator: directed and random traffic,
// shadow heap. Depends on ffa_pkg and the allocator RTL; needs no files or arguments.
module tb_first_fit_free_list_allocator;

    import ffa_pkg::*;

    localparam int SLOTS = CHUNK_SLOTS_DEF;
    localparam int HDR   = HEADER_BYTES_DEF;
    localparam logic [REG_BITS-1:0] ADDR_MAX = 20'hFFFFF;

    typedef logic [REG_BITS-1:0] word_t;

    // One expected result transfer
    typedef struct packed {
        word_t   addr;
        status_t st;
    } answer_t;

    // Shadow copy of the allocator: chunk table, free chain and break pointer.
    // take_request() advances it by one request and queues the answer;
    // match_result() pops the oldest answer and compares it.
    class heap_tracker;
        word_t   base_reg;
        word_t   limit_reg;
        word_t   brk;
        word_t   start_of [SLOTS];
        word_t   bytes_of [SLOTS];
        bit      is_free  [SLOTS];
        int      carved;
        int      n_free;
        int      free_chain [SLOTS];
        answer_t owed [$];
        int      errors;

        function new();
            base_reg  = HEAP_BASE_RESET;
            limit_reg = HEAP_LIMIT_RESET;
            brk       = HEAP_BASE_RESET;
            carved    = 0;
            n_free    = 0;
            errors    = 0;
            foreach (is_free[i]) is_free[i] = 1'b0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, word_t val);
            if (idx == CFG_HEAP_BASE) begin
                base_reg = val;
                // the break pointer follows the base only until the first carve
                if (carved == 0) brk = val;
            end else begin
                limit_reg = val;
            end
        endfunction

        function word_t user_of(int s);
            return start_of[s] + word_t'(HDR);
        endfunction

        function answer_t do_alloc(word_t size);
            answer_t     ans;
            int          hit;
            int          s;
            logic [31:0] nxt;
            ans.addr = '0;
            if (size == '0) begin
                ans.st = ST_ZERO;
                return ans;
            end
            // first fit over the free chain, most recently freed first
            hit = -1;
            for (int k = 0; k < n_free; k++)
                if (hit < 0 && bytes_of[free_chain[k]] >= size) hit = k;
            if (hit >= 0) begin
                s = free_chain[hit];
                for (int j = hit; j + 1 < n_free; j++) free_chain[j] = free_chain[j + 1];
                n_free--;
                is_free[s] = 1'b0;
                ans.addr   = user_of(s);
                ans.st     = ST_REUSED;
                return ans;
            end
            // heap limit is checked before the table
            nxt = 32'(brk) + 32'(HDR) + 32'(size);
            if (nxt > 32'(limit_reg)) begin
                ans.st = ST_HEAP_FULL;
            end else if (carved >= SLOTS) begin
                ans.st = ST_TABLE_FULL;
            end else begin
                start_of[carved] = brk;
                bytes_of[carved] = size;
                is_free[carved]  = 1'b0;
                ans.addr         = user_of(carved);
                ans.st           = ST_NEW;
                carved++;
                brk = word_t'(nxt);
            end
            return ans;
        endfunction

        function answer_t do_free(word_t addr);
            answer_t ans;
            int      hit;
            ans.addr = '0;
            if (addr == '0) begin
                ans.st = ST_NULL;
                return ans;
            end
            hit = -1;
            for (int i = 0; i < carved; i++)
                if (hit < 0 && user_of(i) == addr) hit = i;
            if (hit < 0 || is_free[hit] || n_free >= SLOTS) begin
                ans.st = ST_BAD_FREE;
                return ans;
            end
            for (int j = n_free; j > 0; j--) free_chain[j] = free_chain[j - 1];
            free_chain[0] = hit;
            n_free++;
            is_free[hit] = 1'b1;
            ans.st = ST_FREED;
            return ans;
        endfunction

        function void take_request(logic m, word_t size, word_t addr);
            if (m == MODE_ALLOC) owed.push_back(do_alloc(size));
            else                 owed.push_back(do_free(addr));
        endfunction

        function void match_result(word_t addr, logic [STATUS_BITS-1:0] st);
            answer_t want;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending: user_address=%0d status=%0d",
                         $time, addr, st);
                return;
            end
            want = owed.pop_front();
            if (addr !== want.addr) begin
                errors++;
                $display("%0t: user_address mismatch: expected %0d actual %0d",
                         $time, want.addr, addr);
            end
            if (st !== want.st) begin
                errors++;
                $display("%0t: status mismatch: expected %0d (%s) actual %0d",
                         $time, want.st, want.st.name(), st);
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    // Block inputs start at known values
    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      cfg_write_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = CFG_HEAP_BASE;
    logic [REG_BITS-1:0]       cfg_data     = '0;
    logic                      in_valid     = 1'b0;
    logic                      in_stall;
    logic                      mode         = MODE_ALLOC;
    logic [REG_BITS-1:0]       request_size = '0;
    logic [REG_BITS-1:0]       free_address = '0;
    logic                      out_valid;
    logic                      out_stall    = 1'b0;
    logic [ADDR_BITS_DEF-1:0]  user_address;
    logic [STATUS_BITS-1:0]    status;

    heap_tracker trk = new();

    int burst_left = 0;
    int stall_style = 0;
    int style_left = 0;

    first_fit_free_list_allocator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .request_size (request_size),
        .free_address (free_address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .user_address (user_address),
        .status       (status)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the handshake hangs
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver stall: switch at random between no stall, light and heavy random stall
    // so stalls land on every phase of the block's work.
    always @(posedge clk) begin
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 2);
            style_left  = $urandom_range(20, 200);
        end else begin
            style_left = style_left - 1;
        end
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Sample the result channel mid-cycle: inputs and outputs only move at the
    // rising edge, so what is seen here is what the next edge transfers.
    always @(negedge clk) begin
        if (rst_n && out_valid && !out_stall) trk.match_result(user_address, status);
    end

    // Present one request and hold it until the transfer; note it in the shadow heap.
    task automatic send_request(logic m, word_t sz, word_t fa);
        bit took;
        in_valid     <= 1'b1;
        mode         <= m;
        request_size <= sz;
        free_address <= fa;
        took = 1'b0;
        while (!took) begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        trk.take_request(m, sz, fa);
    endtask

    // Send in bursts; drop valid for a random gap between bursts. A zero gap
    // keeps valid high so it is never lowered and raised in one step.
    task automatic issue(logic m, word_t sz, word_t fa);
        int gap;
        send_request(m, sz, fa);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Hold off until every pending result has arrived and the block is quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (trk.pending() != 0) @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    // Single-cycle register write; call only while the block is idle.
    task automatic program_reg(logic [CFG_INDEX_BITS-1:0] idx, word_t val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        trk.write_reg(idx, val);
        @(posedge clk);
    endtask

    // User address of a carved chunk, in the wanted free state where one exists, or a random
    // address while nothing has been carved yet.
    function automatic word_t chunk_user(bit want_free);
        int s;
        int tries;
        if (trk.carved == 0) return word_t'($urandom_range(1, ADDR_MAX));
        s = $urandom_range(0, trk.carved - 1);
        for (tries = 0; tries < SLOTS && trk.is_free[s] != want_free; tries++)
            s = (s + 1) % trk.carved;
        return trk.user_of(s);
    endfunction

    // Mostly well-formed traffic (allocate, free of a live chunk) with some
    // broken requests mixed in. Unused fields carry random bits too.
    task automatic next_random(output logic m, output word_t sz, output word_t fa);
        int pick;
        pick = $urandom_range(0, 99);
        sz   = word_t'($urandom);
        fa   = word_t'($urandom);
        m    = MODE_FREE;
        if (pick < 40) begin
            m = MODE_ALLOC;
            case ($urandom_range(0, 19))
                0, 1:    sz = word_t'($urandom_range(1, 4096));
                2:       sz = word_t'($urandom);
                default: sz = word_t'($urandom_range(1, 48));
            endcase
        end else if (pick < 72) begin
            fa = chunk_user(1'b0);
        end else if (pick < 80) begin
            fa = chunk_user(1'b1);       // double free when a free chunk exists
        end else if (pick < 86) begin
            // unknown address: random, or just off a real user address
            if ($urandom_range(0, 1) == 0) fa = chunk_user(1'b0) + word_t'($urandom_range(1, 7));
        end else if (pick < 90) begin
            fa = '0;
        end else if (pick < 94) begin
            m  = MODE_ALLOC;
            sz = '0;
        end else begin
            m  = MODE_ALLOC;
            sz = word_t'($urandom_range(ADDR_MAX - 4000, ADDR_MAX));
        end
    endtask

    task automatic run_random(int count, int pause_at);
        logic  m;
        word_t sz;
        word_t fa;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) settle();
            next_random(m, sz, fa);
            issue(m, sz, fa);
        end
    endtask

    initial begin
        int    waited;
        int    lim;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero size, null free, unknown address, heap full
        issue(MODE_ALLOC, '0, '0);
        issue(MODE_FREE, ADDR_MAX, '0);
        issue(MODE_FREE, '0, ADDR_MAX);
        issue(MODE_ALLOC, ADDR_MAX, ADDR_MAX);
        settle();

        // Limit below base: every carve fails as heap full
        program_reg(CFG_HEAP_LIMIT, 20'd1);
        program_reg(CFG_HEAP_BASE, ADDR_MAX);
        issue(MODE_ALLOC, 20'd5, '0);
        settle();

        // Base rewrite before any carve moves the break pointer down to 1
        program_reg(CFG_HEAP_BASE, 20'd1);
        program_reg(CFG_HEAP_LIMIT, ADDR_MAX);
        issue(MODE_ALLOC, 20'd1, '0);
        issue(MODE_ALLOC, 20'd32, '0);
        issue(MODE_FREE, '0, 20'd9);
        issue(MODE_FREE, '0, 20'd9);       // double free
        issue(MODE_FREE, '0, 20'd10);      // not a user address
        issue(MODE_FREE, '0, 20'd1);       // chunk header, not user address
        issue(MODE_ALLOC, 20'd2, '0);      // free chunk too small, carve
        issue(MODE_ALLOC, 20'd1, '0);      // exact fit reuse
        issue(MODE_FREE, '0, 20'd18);
        issue(MODE_ALLOC, 20'd20, '0);     // reuse a larger chunk whole
        issue(MODE_ALLOC, '0, ADDR_MAX);
        issue(MODE_FREE, ADDR_MAX, '0);
        issue(MODE_ALLOC, ADDR_MAX, '0);
        settle();

        // Wide heap: fill the table, then reuse and table full
        run_random(450, 200);
        settle();

        // Base rewrite after carving only changes the register; a tight limit
        // turns most carve attempts into heap full
        lim = int'(trk.brk) + 30;
        if (lim > int'(ADDR_MAX)) lim = int'(ADDR_MAX);
        program_reg(CFG_HEAP_BASE, word_t'($urandom_range(2, ADDR_MAX - 1)));
        program_reg(CFG_HEAP_LIMIT, word_t'(lim));
        run_random(300, -1);
        settle();

        program_reg(CFG_HEAP_BASE, ADDR_MAX);
        program_reg(CFG_HEAP_LIMIT, ADDR_MAX);
        run_random(350, -1);

        // Drain: wait for the last results, bounded, then check that none is missing
        in_valid <= 1'b0;
        waited = 0;
        while (trk.pending() != 0 && waited < 5000) begin
            @(posedge clk);
            waited++;
        end
        repeat (30) @(posedge clk);
        if (trk.pending() != 0) begin
            trk.errors++;
            $display("%0t: %0d results never arrived", $time, trk.pending());
        end

        if (trk.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/ffa_pkg.sv
hdl/ffa_slot_cell.sv
hdl/ffa_free_cell.sv
hdl/first_fit_free_list_allocator.sv
bench/tb_first_fit_free_list_allocator.sv
